[rtl/lz4_frame_decompressor_top_defines.svh]
// assertion macros used by the checker file
`ifndef LZ4_FRAME_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZ4_FRAME_DECOMPRESSOR_TOP_DEFINES_SVH

// condition in the same cycle implies consequence
`define LZ4FD_ASSERT_SAME(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("lz4fd assertion failed");

// condition implies consequence in the next cycle
`define LZ4FD_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("lz4fd assertion failed");

`endif

[rtl/lz4fd_pkg.sv]
// shared constants and types of the lz4 frame decompressor
`default_nettype none
package lz4fd_pkg;
    localparam int HISTORY_DEPTH = 65536;
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);

    localparam logic [31:0] SIG_MODERN  = 32'h184D2204;
    localparam logic [31:0] SIG_LEGACY  = 32'h184C2102;
    localparam logic [23:0] LEGACY_FULL = 24'(8 * 1024 * 1024);
    localparam logic [31:0] SIZE_MASK   = 32'h7FFFFFFF;
    localparam logic [3:0]  NIBBLE_EXT  = 4'h0F;
    localparam logic [7:0]  BYTE_EXT    = 8'd255;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_SIG = 3'd1;
    localparam logic [2:0] ST_BAD_VER = 3'd2;
    localparam logic [2:0] ST_ZERO_OF = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       copy_pending;
        logic       frame_done;
        logic [2:0] status;
    } t_result;
endpackage
`default_nettype wire

[rtl/lz4fd_front.sv]
// input queue that accepts compressed bytes and continue ticks
`default_nettype none
module lz4fd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  lz4fd_pkg::t_item   i_item,
    output logic               o_valid,
    output lz4fd_pkg::t_item   o_item,
    input  logic               i_take
);
    import lz4fd_pkg::*;

    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= r_wp + 2'd1;
            end
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end
endmodule
`default_nettype wire

[rtl/lz4fd_outq.sv]
// result queue toward the consumer
`default_nettype none
module lz4fd_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  lz4fd_pkg::t_result i_res,
    output logic               o_empty,
    input  logic               i_pop,
    output lz4fd_pkg::t_result o_res
);
    import lz4fd_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_res   = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_mem[r_wp] <= i_res;
                r_wp        <= r_wp + 2'd1;
            end
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end
endmodule
`default_nettype wire

[rtl/lz4fd_back.sv]
// frame parser, token decoder and history ring with write forwarding
`default_nettype none
module lz4fd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lz4fd_pkg::t_item   i_in_item,
    output logic               o_in_take,
    output logic               o_res_valid,
    output lz4fd_pkg::t_result o_res,
    input  logic               i_res_ready
);
    import lz4fd_pkg::*;

    typedef enum logic [4:0] {
        PH_SIG, PH_FLG, PH_BD, PH_HDRSKIP, PH_BSIZE, PH_RAW, PH_TOKEN, PH_LITEXT,
        PH_LIT, PH_OFF0, PH_OFF1, PH_MEXT, PH_COPY, PH_BCHK, PH_CCHK, PH_DONE, PH_ERR
    } t_phase;

    localparam logic [HIST_AW:0] DEPTH_W = (HIST_AW + 1)'(HISTORY_DEPTH);

    logic [7:0] r_hist [HISTORY_DEPTH];
    logic [7:0] r_rdata;

    t_phase             r_phase, n_phase;
    logic [3:0]         r_fc, n_fc;
    logic [31:0]        r_aw, n_aw;
    logic               r_legacy, n_legacy, r_bchk, n_bchk, r_csize, n_csize;
    logic               r_cchk, n_cchk, r_dict, n_dict;
    logic [31:0]        r_blen, n_blen, r_bpos, n_bpos, r_rl, n_rl;
    logic [3:0]         r_tmn, n_tmn;
    logic [HIST_AW-1:0] r_widx, n_widx, r_ridx, n_ridx;
    logic [23:0]        r_lbc, n_lbc;
    logic [2:0]         r_err, n_err;

    // second stage: resolves the byte and writes the ring
    logic               r_b_valid, r_b_emit, r_b_copy, r_b_fwd, r_b_pend, r_b_done;
    logic [7:0]         r_b_lit, r_b_fwdbyte;
    logic [HIST_AW-1:0] r_b_waddr;
    logic [2:0]         r_b_status;

    logic               adv, take, emit, emit_copy, refused, compressed;
    logic [7:0]         b, lit, b_byte;
    logic [32:0]        sat_sum;
    logic [15:0]        off_dist;
    logic [HIST_AW:0]   rd_tmp;

    assign adv       = !r_b_valid || i_res_ready;
    assign take      = adv && i_in_valid;
    assign o_in_take = take;
    assign b         = i_in_item.data_byte;
    assign b_byte    = r_b_fwd ? r_b_fwdbyte : (r_b_copy ? r_rdata : r_b_lit);
    assign sat_sum   = {1'b0, r_rl} + {25'b0, b};
    assign off_dist  = {b, r_aw[7:0]};

    always_comb begin
        n_phase = r_phase; n_fc = r_fc; n_aw = r_aw;
        n_legacy = r_legacy; n_bchk = r_bchk; n_csize = r_csize;
        n_cchk = r_cchk; n_dict = r_dict;
        n_blen = r_blen; n_bpos = r_bpos; n_rl = r_rl; n_tmn = r_tmn;
        n_widx = r_widx; n_ridx = r_ridx; n_lbc = r_lbc; n_err = r_err;
        emit = 1'b0; emit_copy = 1'b0; refused = 1'b0; lit = b;
        compressed = 1'b1; rd_tmp = '0;

        if (i_in_item.kind == KIND_TICK) begin
            if (r_phase == PH_COPY) begin
                emit = 1'b1; emit_copy = 1'b1;
                n_ridx = ({1'b0, r_ridx} + 1'b1 >= DEPTH_W) ? '0 : r_ridx + 1'b1;
                n_rl = r_rl - 32'd1;
            end
        end else begin
            unique case (r_phase) inside
                PH_SIG, PH_BSIZE: begin
                    n_aw = r_aw | ({24'b0, b} << {r_fc[1:0], 3'b000});
                    n_fc = r_fc + 4'd1;
                end
                PH_FLG: begin
                    n_bchk = b[4]; n_csize = b[3]; n_cchk = b[2]; n_dict = b[0];
                    n_legacy = 1'b0;
                    if (b[7:6] != 2'b01) begin
                        n_err = ST_BAD_VER; n_phase = PH_ERR;
                    end else n_phase = PH_BD;
                end
                PH_BD: begin
                    n_fc = 4'd1 + (r_csize ? 4'd8 : 4'd0) + (r_dict ? 4'd4 : 4'd0);
                    n_phase = PH_HDRSKIP;
                end
                PH_HDRSKIP: begin
                    n_fc = r_fc - 4'd1;
                    if (n_fc == 4'd0) begin
                        n_aw = '0; n_phase = PH_BSIZE;
                    end
                end
                PH_RAW, PH_LIT: begin
                    emit = 1'b1;
                    n_bpos = r_bpos + 32'd1;
                    if (r_phase == PH_LIT) n_rl = r_rl - 32'd1;
                end
                PH_TOKEN: begin
                    n_bpos = r_bpos + 32'd1;
                    n_tmn = b[3:0];
                    n_rl = {28'b0, b[7:4]};
                end
                PH_LITEXT, PH_MEXT: begin
                    n_bpos = r_bpos + 32'd1;
                    n_rl = sat_sum[32] ? '1 : sat_sum[31:0];
                end
                PH_OFF0: begin
                    n_bpos = r_bpos + 32'd1;
                    n_aw = {24'b0, b};
                    n_phase = PH_OFF1;
                end
                PH_OFF1: begin
                    n_bpos = r_bpos + 32'd1;
                    n_aw = '0;
                    if (off_dist == 16'd0) begin
                        n_err = ST_ZERO_OF; n_phase = PH_ERR;
                    end else begin
                        if ({1'b0, r_widx} >= (HIST_AW + 1)'(off_dist))
                            rd_tmp = {1'b0, r_widx} - (HIST_AW + 1)'(off_dist);
                        else
                            rd_tmp = {1'b0, r_widx} + DEPTH_W - (HIST_AW + 1)'(off_dist);
                        n_ridx = rd_tmp[HIST_AW-1:0];
                        n_rl = 32'd4 + {28'b0, r_tmn};
                        n_phase = (r_tmn == NIBBLE_EXT) ? PH_MEXT : PH_COPY;
                    end
                end
                PH_COPY: refused = 1'b1;
                PH_BCHK, PH_CCHK: n_fc = r_fc + 4'd1;
                PH_DONE, PH_ERR: ;
                default: ;
            endcase
        end

        if (emit) begin
            n_widx = ({1'b0, r_widx} + 1'b1 >= DEPTH_W) ? '0 : r_widx + 1'b1;
            if (r_lbc < LEGACY_FULL) n_lbc = r_lbc + 24'd1;
        end

        // phase transitions that need the updated counters
        if (i_in_item.kind == KIND_TICK) begin
            if (r_phase == PH_COPY && n_rl == 32'd0)
                n_phase = (r_bpos < r_blen) ? PH_TOKEN : PH_BCHK;
        end else begin
            case (r_phase)
                PH_SIG: if (n_fc == 4'd4) begin
                    n_fc = '0;
                    if (n_aw == SIG_MODERN) n_phase = PH_FLG;
                    else if (n_aw == SIG_LEGACY) begin
                        n_legacy = 1'b1; n_aw = '0; n_phase = PH_BSIZE;
                    end else begin
                        n_err = ST_BAD_SIG; n_phase = PH_ERR;
                    end
                end
                PH_BSIZE: if (n_fc == 4'd4) begin
                    n_fc = '0;
                    if (r_legacy) n_blen = n_aw;
                    else begin
                        compressed = !n_aw[31];
                        n_blen = n_aw & SIZE_MASK;
                    end
                    n_aw = '0; n_bpos = '0; n_lbc = '0;
                    if (n_blen == 32'd0) n_phase = r_cchk ? PH_CCHK : PH_DONE;
                    else n_phase = compressed ? PH_TOKEN : PH_RAW;
                end
                PH_RAW: if (n_bpos == r_blen) n_phase = PH_BCHK;
                PH_TOKEN: begin
                    if (n_rl[3:0] == NIBBLE_EXT) n_phase = PH_LITEXT;
                    else if (n_rl != 32'd0) n_phase = PH_LIT;
                    else n_phase = (n_bpos == r_blen) ? PH_BCHK : PH_OFF0;
                end
                PH_LITEXT: if (b != BYTE_EXT) begin
                    if (n_rl != 32'd0) n_phase = PH_LIT;
                    else n_phase = (n_bpos == r_blen) ? PH_BCHK : PH_OFF0;
                end
                PH_LIT: if (n_rl == 32'd0)
                    n_phase = (n_bpos == r_blen) ? PH_BCHK : PH_OFF0;
                PH_MEXT: if (b != BYTE_EXT) n_phase = PH_COPY;
                PH_BCHK: if (n_fc == 4'd4) begin
                    n_fc = '0; n_aw = '0; n_phase = PH_BSIZE;
                end
                PH_CCHK: if (n_fc == 4'd4) begin
                    n_fc = '0; n_phase = PH_DONE;
                end
                default: ;
            endcase
        end

        // PH_BCHK above marks a block end; resolve it to the real next phase
        if (n_phase == PH_BCHK && r_phase != PH_BCHK) begin
            n_fc = '0; n_aw = '0;
            if (r_legacy) n_phase = (n_lbc < LEGACY_FULL) ? PH_DONE : PH_BSIZE;
            else n_phase = r_bchk ? PH_BCHK : PH_BSIZE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rdata <= r_hist[r_ridx];
            if (r_b_valid && r_b_emit) r_hist[r_b_waddr] <= b_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG; r_fc <= '0; r_aw <= '0;
            r_legacy <= 1'b0; r_bchk <= 1'b0; r_csize <= 1'b0;
            r_cchk <= 1'b0; r_dict <= 1'b0;
            r_blen <= '0; r_bpos <= '0; r_rl <= '0; r_tmn <= '0;
            r_widx <= '0; r_ridx <= '0; r_lbc <= '0; r_err <= ST_OK;
            r_b_valid <= 1'b0;
            r_b_emit <= 1'b0; r_b_copy <= 1'b0; r_b_lit <= '0; r_b_waddr <= '0;
            r_b_fwd <= 1'b0; r_b_fwdbyte <= '0; r_b_pend <= 1'b0; r_b_done <= 1'b0;
            r_b_status <= ST_OK;
        end else if (adv) begin
            r_b_valid <= take;
            if (take) begin
                r_phase <= n_phase; r_fc <= n_fc; r_aw <= n_aw;
                r_legacy <= n_legacy; r_bchk <= n_bchk; r_csize <= n_csize;
                r_cchk <= n_cchk; r_dict <= n_dict;
                r_blen <= n_blen; r_bpos <= n_bpos; r_rl <= n_rl; r_tmn <= n_tmn;
                r_widx <= n_widx; r_ridx <= n_ridx; r_lbc <= n_lbc; r_err <= n_err;
            end
            r_b_emit    <= emit;
            r_b_copy    <= emit_copy;
            r_b_lit     <= lit;
            r_b_waddr   <= r_widx;
            // read of the address the second stage writes in this same cycle
            r_b_fwd     <= emit_copy && r_b_valid && r_b_emit && (r_b_waddr == r_ridx);
            r_b_fwdbyte <= b_byte;
            r_b_pend    <= (n_phase == PH_COPY);
            r_b_done    <= (n_phase == PH_DONE);
            r_b_status  <= refused ? ST_REFUSED : n_err;
        end
    end

    assign o_res_valid        = r_b_valid;
    assign o_res.out_valid    = r_b_emit;
    assign o_res.out_byte     = r_b_emit ? b_byte : 8'd0;
    assign o_res.copy_pending = r_b_pend;
    assign o_res.frame_done   = r_b_done;
    assign o_res.status       = r_b_status;
endmodule
`default_nettype wire

[rtl/lz4_frame_decompressor_top.sv]
// top level of the lz4 frame decompressor
`default_nettype none
// Decodes one LZ4 frame (modern or legacy) one transaction per cycle while the result queue
// has room: each compressed byte or continue tick yields exactly one result, registered in
// the second stage before it enters the result queue. The rate is held by the 64 KiB history
// ring's single read port, whose registered read is bypassed by forwarding from the write
// stage, so overlapping match copies also run at one byte per cycle. Four-entry queues on
// both sides let producer and consumer stall independently.
module lz4_frame_decompressor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_copy_pending,
    output logic       o_frame_done,
    output logic [2:0] o_status
);
    import lz4fd_pkg::*;

    t_item   in_item, q_item;
    t_result res, out_res;
    logic    q_valid, q_take, res_valid, oq_full;

    assign in_item.kind      = i_kind;
    assign in_item.data_byte = i_data_byte;

    lz4fd_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item(in_item),
        .o_valid(q_valid), .o_item(q_item), .i_take(q_take)
    );

    lz4fd_back u_back (
        .i_clk, .i_rst_n, .i_in_valid(q_valid), .i_in_item(q_item), .o_in_take(q_take),
        .o_res_valid(res_valid), .o_res(res), .i_res_ready(!oq_full)
    );

    lz4fd_outq u_outq (
        .i_clk, .i_rst_n, .i_push(res_valid), .o_full(oq_full), .i_res(res),
        .o_empty(empty), .i_pop(pop), .o_res(out_res)
    );

    assign o_out_valid    = out_res.out_valid;
    assign o_out_byte     = out_res.out_byte;
    assign o_copy_pending = out_res.copy_pending;
    assign o_frame_done   = out_res.frame_done;
    assign o_status       = out_res.status;
endmodule
`default_nettype wire

[rtl/lz4fd_checker.sv]
// port-level checker for the lz4 frame decompressor and its bind
`default_nettype none
`include "lz4_frame_decompressor_top_defines.svh"
module lz4fd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       o_out_valid,
    input logic [7:0] o_out_byte,
    input logic       o_copy_pending,
    input logic       o_frame_done,
    input logic [2:0] o_status
);
    import lz4fd_pkg::*;

    logic hard_err;

    assign hard_err = (o_status == ST_BAD_SIG) || (o_status == ST_BAD_VER)
                   || (o_status == ST_ZERO_OF);

    `LZ4FD_ASSERT_SAME(a_byte_zero, i_clk, i_rst_n, !empty && !o_out_valid, o_out_byte == 8'd0)
    `LZ4FD_ASSERT_SAME(a_done_xor_copy, i_clk, i_rst_n, !empty, !(o_frame_done && o_copy_pending))
    `LZ4FD_ASSERT_SAME(a_err_no_out, i_clk, i_rst_n, !empty && hard_err, !o_out_valid)
    `LZ4FD_ASSERT_NEXT(a_empty_after_rst, i_clk, 1'b1, !i_rst_n, empty && !full)
endmodule

bind lz4_frame_decompressor_top lz4fd_checker u_checker (
    .i_clk, .i_rst_n, .full, .empty, .o_out_valid, .o_out_byte,
    .o_copy_pending, .o_frame_done, .o_status
);
`default_nettype wire

[test/tb_lz4_frame_decompressor_top.sv]
// testbench for the lz4 frame decompressor: random frames checked against a software decoder
`timescale 1ns / 100ps
`default_nettype none
module tb_lz4_frame_decompressor_top;
    import lz4fd_pkg::*;

    typedef enum logic [4:0] {
        S_SIG, S_FLG, S_BD, S_HDRSKIP, S_BSIZE, S_RAW, S_TOKEN, S_LITEXT, S_LIT,
        S_OFF0, S_OFF1, S_MEXT, S_COPY, S_BCHK, S_CCHK, S_DONE, S_ERR
    } t_phase;

    typedef bit bool_t;

    localparam logic [5:0] FL_LEGACY = 6'd1;
    localparam logic [5:0] FL_BCHK   = 6'd2;
    localparam logic [5:0] FL_CSIZE  = 6'd4;
    localparam logic [5:0] FL_CCHK   = 6'd8;
    localparam logic [5:0] FL_DICT   = 6'd16;
    localparam int CYCLE_LIMIT = 3000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic       i_kind = KIND_BYTE;
    logic [7:0] i_data_byte = 8'd0;
    logic       full, empty;
    logic       o_out_valid, o_copy_pending, o_frame_done;
    logic [7:0] o_out_byte;
    logic [2:0] o_status;

    lz4_frame_decompressor_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_kind(i_kind), .i_data_byte(i_data_byte), .empty(empty), .pop(pop),
        .o_out_valid(o_out_valid), .o_out_byte(o_out_byte),
        .o_copy_pending(o_copy_pending), .o_frame_done(o_frame_done), .o_status(o_status)
    );

    always #2 i_clk = ~i_clk;

    // decoder state
    t_phase      ph;
    logic [3:0]  fcnt;
    logic [31:0] aword;
    logic [5:0]  fflags;
    logic [31:0] blen, bpos, runlen;
    logic [3:0]  mnib;
    logic [15:0] mdist, widx, ridx;
    logic [23:0] legacy_cnt;
    logic [2:0]  err_code;
    logic [7:0]  history [0:HISTORY_DEPTH-1];
    int          hist_fill;

    t_result     decoded_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    bool_t       calm;
    int          scenario;
    bit          finishing;
    bit          first_block;
    logic [31:0] sig_word, size_word;
    int          rx_stall = 0;

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [7:0] b);
        logic [32:0] s;
        s = {1'b0, a} + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [7:0] emit_byte(logic [7:0] b);
        history[widx] = b;
        widx = widx + 16'd1;
        if (hist_fill < HISTORY_DEPTH) hist_fill++;
        if (legacy_cnt < LEGACY_FULL) legacy_cnt = legacy_cnt + 24'd1;
        return b;
    endfunction

    function automatic void end_block();
        fcnt = 0;
        aword = 0;
        if (fflags & FL_LEGACY) ph = (legacy_cnt < LEGACY_FULL) ? S_DONE : S_BSIZE;
        else ph = (fflags & FL_BCHK) ? S_BCHK : S_BSIZE;
    endfunction

    function automatic void after_literals();
        if (bpos == blen) end_block();
        else ph = S_OFF0;
    endfunction

    function automatic void start_literals();
        if (runlen != 0) ph = S_LIT;
        else after_literals();
    endfunction

    function automatic t_result decode_item(logic kind, logic [7:0] b);
        t_result r;
        bit refused;
        logic [31:0] sz;
        bit compressed;
        r = '0;
        refused = 0;
        if (kind == KIND_TICK) begin
            if (ph == S_COPY) begin
                r.out_byte = emit_byte(history[ridx]);
                r.out_valid = 1'b1;
                ridx = ridx + 16'd1;
                runlen = runlen - 1;
                if (runlen == 0) begin
                    if (bpos < blen) ph = S_TOKEN;
                    else end_block();
                end
            end
        end else begin
            case (ph) inside
                S_SIG, S_BSIZE: begin
                    aword = aword | (32'(b) << (8 * fcnt[1:0]));
                    fcnt = fcnt + 1;
                    if (fcnt == 4) begin
                        fcnt = 0;
                        if (ph == S_SIG) begin
                            if (aword == SIG_MODERN) begin
                                ph = S_FLG;
                            end else if (aword == SIG_LEGACY) begin
                                fflags = FL_LEGACY;
                                aword = 0;
                                ph = S_BSIZE;
                            end else begin
                                err_code = ST_BAD_SIG;
                                ph = S_ERR;
                            end
                        end else begin
                            if (fflags & FL_LEGACY) begin
                                compressed = 1;
                                sz = aword;
                            end else begin
                                compressed = !aword[31];
                                sz = aword & SIZE_MASK;
                            end
                            blen = sz;
                            aword = 0;
                            bpos = 0;
                            legacy_cnt = 0;
                            if (blen == 0) ph = (fflags & FL_CCHK) ? S_CCHK : S_DONE;
                            else ph = compressed ? S_TOKEN : S_RAW;
                        end
                    end
                end
                S_FLG: begin
                    fflags = (b[4] ? FL_BCHK : 6'd0) | (b[3] ? FL_CSIZE : 6'd0)
                           | (b[2] ? FL_CCHK : 6'd0) | (b[0] ? FL_DICT : 6'd0);
                    if (b[7:6] != 2'b01) begin
                        err_code = ST_BAD_VER;
                        ph = S_ERR;
                    end else begin
                        ph = S_BD;
                    end
                end
                S_BD: begin
                    fcnt = 4'd1 + ((fflags & FL_CSIZE) ? 4'd8 : 4'd0)
                         + ((fflags & FL_DICT) ? 4'd4 : 4'd0);
                    ph = S_HDRSKIP;
                end
                S_HDRSKIP: begin
                    fcnt = fcnt - 1;
                    if (fcnt == 0) begin
                        aword = 0;
                        ph = S_BSIZE;
                    end
                end
                S_RAW: begin
                    r.out_byte = emit_byte(b);
                    r.out_valid = 1'b1;
                    bpos = bpos + 1;
                    if (bpos == blen) end_block();
                end
                S_TOKEN: begin
                    bpos = bpos + 1;
                    mnib = b[3:0];
                    runlen = 32'(b[7:4]);
                    if (runlen == 15) ph = S_LITEXT;
                    else start_literals();
                end
                S_LITEXT: begin
                    bpos = bpos + 1;
                    runlen = sat_add(runlen, b);
                    if (b != BYTE_EXT) start_literals();
                end
                S_LIT: begin
                    r.out_byte = emit_byte(b);
                    r.out_valid = 1'b1;
                    bpos = bpos + 1;
                    runlen = runlen - 1;
                    if (runlen == 0) after_literals();
                end
                S_OFF0: begin
                    bpos = bpos + 1;
                    aword = 32'(b);
                    ph = S_OFF1;
                end
                S_OFF1: begin
                    bpos = bpos + 1;
                    mdist = {b, aword[7:0]};
                    aword = 0;
                    if (mdist == 0) begin
                        err_code = ST_ZERO_OF;
                        ph = S_ERR;
                    end else begin
                        ridx = widx - mdist;
                        runlen = 32'd4 + mnib;
                        ph = (mnib == NIBBLE_EXT) ? S_MEXT : S_COPY;
                    end
                end
                S_MEXT: begin
                    bpos = bpos + 1;
                    runlen = sat_add(runlen, b);
                    if (b != BYTE_EXT) ph = S_COPY;
                end
                S_COPY: refused = 1;
                S_BCHK, S_CCHK: begin
                    fcnt = fcnt + 1;
                    if (fcnt == 4) begin
                        fcnt = 0;
                        if (ph == S_BCHK) begin
                            aword = 0;
                            ph = S_BSIZE;
                        end else begin
                            ph = S_DONE;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.status = refused ? ST_REFUSED : err_code;
        r.copy_pending = (ph == S_COPY);
        r.frame_done = (ph == S_DONE);
        return r;
    endfunction

    function automatic logic [7:0] ext_byte();
        return ($urandom_range(0, 5) == 0) ? BYTE_EXT : 8'($urandom_range(0, 10));
    endfunction

    // picks the next item from the decoder phase; frames stay well formed but for the noise and error scenarios
    task automatic pick_item(output logic k, output logic [7:0] b);
        logic [15:0] d;
        k = KIND_BYTE;
        b = 8'($urandom);
        case (ph) inside
            S_SIG: b = sig_word[8 * fcnt[1:0] +: 8];
            S_FLG: b = {(scenario == 1) ? 2'b11 : 2'b01, 6'($urandom)};
            S_BSIZE: begin
                if (fcnt == 0) begin
                    if (finishing) size_word = 0;
                    else if (fflags & FL_LEGACY) size_word = $urandom_range(1200, 2000);
                    else if (first_block || $urandom_range(0, 3) == 0)
                        size_word = 32'h8000_0000 | $urandom_range(1, 48);
                    else size_word = $urandom_range(1, 48);
                    first_block = 0;
                end
                b = size_word[8 * fcnt[1:0] +: 8];
            end
            S_TOKEN: begin
                b[7:4] = finishing ? 4'($urandom_range(0, 2))
                       : ($urandom_range(0, 5) == 0) ? 4'hF : 4'($urandom_range(0, 4));
            end
            S_LITEXT, S_MEXT: b = ext_byte();
            S_COPY: if ($urandom_range(0, 9) != 0) k = KIND_TICK;
            default: ;
        endcase
        // noise: random transaction, kept out of the signature, flag and block size phases
        if (!(ph inside {S_SIG, S_FLG, S_BSIZE}) && $urandom_range(0, 39) == 0) begin
            k = 1'($urandom);
            b = 8'($urandom);
        end
        if (k == KIND_BYTE) begin
            if (ph == S_TOKEN && hist_fill == 0 && b[7:4] == 0) b[7:4] = 4'd1;
            // offsets never reach history that was not written
            if (ph == S_OFF0) begin
                if (scenario == 2 && finishing) b = 0;
                else if (hist_fill < 256)
                    b = (hist_fill == 0) ? 8'd0 : 8'(1 + $urandom_range(0, hist_fill - 1));
                else if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(1, 12));
            end else if (ph == S_OFF1) begin
                d = {b, aword[7:0]};
                if ((scenario == 2 && finishing) || int'(d) > hist_fill || $urandom_range(0, 1))
                    b = 0;
            end
        end
    endtask

    task automatic send_item(logic k, logic [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        push = 1'b1;
        i_kind = k;
        i_data_byte = b;
        #1;
        while (full) begin
            @(negedge i_clk);
            #1;
        end
        decoded_q.push_back(decode_item(k, b));
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic run_items(int n);
        logic k;
        logic [7:0] b;
        repeat (n) begin
            pick_item(k, b);
            send_item(k, b);
        end
    endtask

    task automatic test_header();
        run_items(20);
    endtask

    task automatic test_random_stream();
        run_items(700);
    endtask

    task automatic test_drain_pause();
        wait (decoded_q.size() == 0);
        run_items(700);
    endtask

    task automatic test_frame_end();
        int guard;
        calm = 1;
        finishing = 1;
        guard = 0;
        while (!(ph inside {S_DONE, S_ERR}) && guard < 30000) begin
            run_items(1);
            guard++;
        end
        run_items(6);
    endtask

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, actual %0d", name, exp_v, got_v);
        end
    endtask

    // result side: pop decided at the falling edge, transaction taken at the next rising edge
    always @(negedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            pop = 1'b0;
        end else begin
            if (rx_stall > 0) begin
                pop = 1'b0;
                rx_stall--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                rx_stall = $urandom_range(0, 2);
            end else begin
                pop = 1'b1;
            end
            #1;
            if (pop && !empty) begin
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: result with none expected");
                end else begin
                    exp_r = decoded_q.pop_front();
                    check_field("out_valid", exp_r.out_valid, o_out_valid);
                    check_field("out_byte", exp_r.out_byte, o_out_byte);
                    check_field("copy_pending", exp_r.copy_pending, o_copy_pending);
                    check_field("frame_done", exp_r.frame_done, o_frame_done);
                    check_field("status", exp_r.status, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        ph = S_SIG;
        fcnt = 0; aword = 0; fflags = 0; blen = 0; bpos = 0; runlen = 0; mnib = 0;
        mdist = 0; widx = 0; ridx = 0; legacy_cnt = 0; err_code = ST_OK; hist_fill = 0;
        calm = 0;
        finishing = 0;
        first_block = 1;
        size_word = 0;
        scenario = $urandom_range(0, 9);
        if (scenario == 0) sig_word = SIG_MODERN ^ 32'h0100_0000;
        else if (scenario inside {3, 4}) sig_word = SIG_LEGACY;
        else sig_word = SIG_MODERN;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_header();
        test_random_stream();
        test_drain_pause();
        test_frame_end();
        wait (decoded_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

[lz4_frame_decompressor_top.f]
+incdir+rtl
rtl/lz4fd_pkg.sv
rtl/lz4fd_front.sv
rtl/lz4fd_outq.sv
rtl/lz4fd_back.sv
rtl/lz4_frame_decompressor_top.sv
rtl/lz4fd_checker.sv
test/tb_lz4_frame_decompressor_top.sv
